// ===== src/hcbp_pkg.sv =====
// shared types and constants of the huffman code bit packer
package hcbp_pkg;

  localparam int MAX_CODE_LEN  = 24;
  localparam int ALPHABET_SIZE = 256;
  localparam int CODE_W        = 24;
  localparam int SYM_W         = 8;
  localparam int LEN_W         = 5;
  localparam int CMD_W         = 2;
  localparam int BYTE_W        = 8;
  localparam int LEN_LIM       = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int SR_W          = CODE_W + BYTE_W;
  localparam int TOT_W         = $clog2(SR_W);
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } hcbp_cmd_t;

  typedef struct packed {
    logic              flush;
    logic [CODE_W-1:0] code_al;
    logic [LEN_W-1:0]  len;
  } hcbp_entry_t;

endpackage

// ===== src/hcbp_if.sv =====
// valid/ready channel interfaces for the input commands and the output bytes
interface hcbp_in_if import hcbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SYM_W-1:0]  symbol;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_len;

  modport source (output valid, output cmd, output symbol, output code_bits,
                  output code_len, input ready);
  modport sink (input valid, input cmd, input symbol, input code_bits,
                input code_len, output ready);
endinterface

interface hcbp_out_if import hcbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

// ===== src/huffman_code_bit_packer.sv =====
// Huffman code bit packer: byte symbols in, msb-first packed code bytes out
//
// in_ch carries commands: write a table entry, encode a symbol, or flush the
// pending bits. A command is taken when valid and ready are both high.
// out_ch returns packed bytes, earliest code bit in bit 7, with last set on
// the final byte that one command causes (up to three bytes per symbol).
// Writes, symbols without a code and flushes with nothing pending give no byte.
// A command goes through the table read register and the queue to the single
// output register. Throughput is one command per cycle while each symbol completes
// at most one byte and out_ch is ready; a symbol that completes n bytes holds
// the bit packer until all are out, one byte per cycle through that register.
// A four-entry queue sits between the table lookup and the bit packer, so
// commands keep being accepted while the receiver stalls until it fills.
// Reset clears the code table (all lengths zero), the pending bits and the
// queue; no clearing pass is needed.
module huffman_code_bit_packer import hcbp_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  hcbp_in_if.sink     in_ch,
  hcbp_out_if.source  out_ch
);

  hcbp_entry_t push_data;
  hcbp_entry_t pop_data;
  logic        push_valid;
  logic        fifo_full;
  logic        fifo_empty;
  logic        pop;

  hcbp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_data  (push_data),
    .push_valid (push_valid),
    .fifo_full  (fifo_full)
  );

  hcbp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (fifo_full),
    .empty     (fifo_empty)
  );

  hcbp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_data (pop_data),
    .empty    (fifo_empty),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// ===== src/hcbp_front.sv =====
// front end: code table, command decode and code alignment
module hcbp_front import hcbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  hcbp_in_if.sink     in_ch,
  output hcbp_entry_t push_data,
  output logic        push_valid,
  input  logic        fifo_full
);

  logic [CODE_W-1:0]        mem_code [ALPHABET_SIZE];
  logic [LEN_W-1:0]         mem_len  [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] vld_r;

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_flush_r;
  logic [CODE_W-1:0] rd_code_r;
  logic [LEN_W-1:0]  rd_len_r;
  logic              rd_vld_r;

  logic              accept;
  logic              in_alpha;
  logic [LEN_W-1:0]  wr_len;
  logic [LEN_W-1:0]  eff_len;
  logic              s1_adv;

  assign in_alpha = ({1'b0, in_ch.symbol} < (SYM_W+1)'(ALPHABET_SIZE));
  assign wr_len   = (in_ch.code_len > LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM) : in_ch.code_len;
  assign s1_adv   = s1_valid_r && !fifo_full;
  assign in_ch.ready = !s1_valid_r || !fifo_full;
  assign accept   = in_ch.valid && in_ch.ready;

  // table storage, read data registered
  always_ff @(posedge clk) begin
    if (accept && in_ch.cmd == CMD_WRITE && in_alpha) begin
      mem_code[in_ch.symbol[SYM_W-1:0]] <= in_ch.code_bits;
      mem_len[in_ch.symbol[SYM_W-1:0]]  <= wr_len;
    end
    if (accept) begin
      rd_code_r  <= mem_code[in_ch.symbol[SYM_W-1:0]];
      rd_len_r   <= mem_len[in_ch.symbol[SYM_W-1:0]];
      rd_vld_r   <= in_alpha && vld_r[in_ch.symbol];
      s1_flush_r <= (in_ch.cmd == CMD_FLUSH);
    end
  end

  // per-entry valid bits give the all-zero reset of the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (accept && in_ch.cmd == CMD_WRITE && in_alpha) begin
      vld_r[in_ch.symbol] <= 1'b1;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_adv) s1_valid_nxt = 1'b0;
    if (accept) s1_valid_nxt = (in_ch.cmd == CMD_ENCODE) || (in_ch.cmd == CMD_FLUSH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  assign eff_len = rd_vld_r ? rd_len_r : '0;

  // left-align the code so its first bit sits at the msb; bits above len fall off
  always_comb begin
    push_data.flush   = s1_flush_r;
    push_data.len     = eff_len;
    push_data.code_al = rd_code_r << (LEN_W'(CODE_W) - eff_len);
  end

  // symbols without a code are dropped here
  assign push_valid = s1_adv && (s1_flush_r || eff_len != '0);

endmodule

// ===== src/hcbp_fifo.sv =====
// short queue between the front end and the bit packer
module hcbp_fifo import hcbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  hcbp_entry_t push_data,
  input  logic        pop,
  output hcbp_entry_t pop_data,
  output logic        full,
  output logic        empty
);

  hcbp_entry_t        ent_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== src/hcbp_back.sv =====
// back end: msb-first bit accumulator and output byte register
module hcbp_back import hcbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  hcbp_entry_t pop_data,
  input  logic        empty,
  output logic        pop,
  hcbp_out_if.source  out_ch
);

  logic [SR_W-1:0]   sr_r, sr_nxt;
  logic [TOT_W-1:0]  tot_r, tot_nxt;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  logic              slot_free;
  logic              emit;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_last;
  logic [SR_W-1:0]   merged;
  logic [TOT_W-1:0]  new_tot;
  logic [TOT_W-1:0]  rem;

  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    merged = sr_r | ({pop_data.code_al, BYTE_W'(0)} >> tot_r);
    new_tot = tot_r + TOT_W'(pop_data.len);
    rem = '0;
    emit = 1'b0;
    pop = 1'b0;
    emit_byte = sr_r[SR_W-1 -: BYTE_W];
    emit_last = 1'b0;
    sr_nxt = sr_r;
    tot_nxt = tot_r;
    if (tot_r >= TOT_W'(BYTE_W)) begin
      // drain whole bytes left from the previous symbol
      if (slot_free) begin
        rem       = tot_r - TOT_W'(BYTE_W);
        emit      = 1'b1;
        emit_last = (rem < TOT_W'(BYTE_W));
        sr_nxt    = sr_r << BYTE_W;
        tot_nxt   = rem;
      end
    end else if (!empty) begin
      if (pop_data.flush) begin
        if (tot_r == '0) begin
          pop = 1'b1;
        end else if (slot_free) begin
          pop       = 1'b1;
          emit      = 1'b1;
          emit_last = 1'b1;
          sr_nxt    = '0;
          tot_nxt   = '0;
        end
      end else begin
        pop = 1'b1;
        if (new_tot >= TOT_W'(BYTE_W) && slot_free) begin
          rem       = new_tot - TOT_W'(BYTE_W);
          emit      = 1'b1;
          emit_byte = merged[SR_W-1 -: BYTE_W];
          emit_last = (rem < TOT_W'(BYTE_W));
          sr_nxt    = merged << BYTE_W;
          tot_nxt   = rem;
        end else begin
          sr_nxt  = merged;
          tot_nxt = new_tot;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r        <= '0;
      tot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sr_r  <= sr_nxt;
      tot_r <= tot_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last     = out_last_r;

endmodule

// ===== src/hcbp_chk.sv =====
// port-level checker for the bit packer, bound to the top level
module hcbp_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);

  logic [1:0] run_r;

  // count bytes of the current run that are not marked last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (out_valid && out_ready) begin
      run_r <= out_last ? 2'd0 : ((run_r == 2'd3) ? run_r : run_r + 2'd1);
    end
  end

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output transaction dropped while stalled");

  a_max_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |-> run_r < 2'd2)
    else $error("more than three bytes without last");

  a_ready_rst: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind huffman_code_bit_packer hcbp_chk u_hcbp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last)
);

// ===== test/testbench.sv =====
// self-checking testbench for huffman_code_bit_packer: directed and random command streams
module testbench import hcbp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  logic clk;
  logic rst_n;

  hcbp_in_if  in_ch();
  hcbp_out_if out_ch();

  huffman_code_bit_packer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the code table and the bit buffer
  logic [CODE_W-1:0] code_value [ALPHABET_SIZE];
  logic [LEN_W-1:0]  code_length [ALPHABET_SIZE];
  logic [6:0]        pend_bits;
  int unsigned       pend_cnt;

  packed_byte_t expected_bytes[$];

  int in_idle_pct;
  int out_stall_pct;
  int mismatches;
  int bytes_checked;
  int n_write, n_encode, n_flush, n_unknown;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("huffman_code_bit_packer regression: fail");
    $finish;
  end

  // receiver side: ready changes on the falling edge only
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  function automatic void report_mismatch(input string what, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $time, what, exp_v, act_v);
  endfunction

  // updates the shadow state for one accepted transaction and queues its bytes
  function automatic void predict_packing(input logic [CMD_W-1:0] c,
                                          input logic [SYM_W-1:0] sym,
                                          input logic [CODE_W-1:0] bits,
                                          input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] clen;
    logic [63:0]      acc;
    logic [7:0]       tail;
    int unsigned      total;
    packed_byte_t     b;
    case (c)
      CMD_WRITE: begin
        n_write++;
        clen = (len > LEN_LIM) ? LEN_LIM[LEN_W-1:0] : len;
        code_value[sym]  = bits;
        code_length[sym] = clen;
      end
      CMD_ENCODE: begin
        n_encode++;
        clen = code_length[sym];
        if (clen != 0) begin
          acc = (64'(pend_bits) << clen) |
                (64'(code_value[sym]) & ((64'd1 << clen) - 64'd1));
          total = pend_cnt + clen;
          while (total >= 8) begin
            b.data = 8'(acc >> (total - 8));
            b.last = (total - 8 < 8);
            expected_bytes.push_back(b);
            total -= 8;
          end
          pend_cnt  = total;
          pend_bits = 7'(acc & ((64'd1 << total) - 64'd1));
        end
      end
      CMD_FLUSH: begin
        n_flush++;
        if (pend_cnt != 0) begin
          tail = {1'b0, pend_bits};
          b.data = tail << (8 - pend_cnt);
          b.last = 1'b1;
          expected_bytes.push_back(b);
          pend_bits = '0;
          pend_cnt  = 0;
        end
      end
      default: n_unknown++;
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    packed_byte_t exp_b;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected byte", 32'h0, {23'h0, out_ch.out_byte, out_ch.last});
      end else begin
        exp_b = expected_bytes.pop_front();
        if (out_ch.out_byte !== exp_b.data)
          report_mismatch("out_byte", exp_b.data, out_ch.out_byte);
        if (out_ch.last !== exp_b.last)
          report_mismatch("last", exp_b.last, out_ch.last);
      end
    end
  end

  // drives one transaction; valid stays high afterwards until the next call or a pause
  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [SYM_W-1:0] sym,
                          input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= c;
    in_ch.symbol    <= sym;
    in_ch.code_bits <= bits;
    in_ch.code_len  <= len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_packing(c, sym, bits, len);
  endtask

  task automatic wait_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    // lookup and queue stages may still hold commands that give no byte
    repeat (8) @(negedge clk);
  endtask

  task automatic test_empty_table();
    send_cmd(CMD_ENCODE, 8'd0, 24'h0, 5'd0);
    send_cmd(CMD_FLUSH, 8'd0, 24'h0, 5'd0);
    send_cmd(CMD_UNKNOWN, 8'hff, 24'hffffff, 5'd31);
  endtask

  task automatic test_directed_codes();
    send_cmd(CMD_WRITE, 8'd255, 24'hffffff, 5'd24);
    // high code bits beyond the length must be dropped
    send_cmd(CMD_WRITE, 8'd0, 24'hfffffe, 5'd1);
    // oversize length saturates
    send_cmd(CMD_WRITE, 8'd1, 24'ha5c3f0, 5'd31);
    send_cmd(CMD_WRITE, 8'd2, 24'h00003c, 5'd8);
    send_cmd(CMD_WRITE, 8'd3, 24'hffffff, 5'd0);
    send_cmd(CMD_WRITE, 8'd4, 24'h000005, 5'd3);
    send_cmd(CMD_WRITE, 8'd128, 24'h000001, 5'd1);
    send_cmd(CMD_ENCODE, 8'd255, 24'h0, 5'd0);
    send_cmd(CMD_ENCODE, 8'd0, 24'h0, 5'd0);
    send_cmd(CMD_ENCODE, 8'd255, 24'h0, 5'd0);
    send_cmd(CMD_ENCODE, 8'd3, 24'h0, 5'd0);
    send_cmd(CMD_UNKNOWN, 8'd4, 24'h123456, 5'd7);
    send_cmd(CMD_FLUSH, 8'd0, 24'h0, 5'd0);
    send_cmd(CMD_FLUSH, 8'd0, 24'h0, 5'd0);
    // build up seven pending bits, then push the longest code through
    send_cmd(CMD_ENCODE, 8'd4, 24'h0, 5'd0);
    send_cmd(CMD_ENCODE, 8'd4, 24'h0, 5'd0);
    send_cmd(CMD_ENCODE, 8'd128, 24'h0, 5'd0);
    send_cmd(CMD_ENCODE, 8'd1, 24'h0, 5'd0);
    send_cmd(CMD_ENCODE, 8'd2, 24'h0, 5'd0);
    send_cmd(CMD_ENCODE, 8'd128, 24'h0, 5'd0);
    send_cmd(CMD_ENCODE, 8'd4, 24'h0, 5'd0);
    send_cmd(CMD_FLUSH, 8'd0, 24'h0, 5'd0);
  endtask

  task automatic send_random_cmd();
    int r, l;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
    r    = $urandom_range(99);
    // mostly a small working alphabet so encodes hit written entries
    sym  = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(31));
    bits = 24'($urandom);
    len  = 5'($urandom);
    if (r < 22) begin
      l = $urandom_range(9);
      if (l == 0)      len = 5'd0;
      else if (l == 1) len = 5'($urandom_range(31, 25));
      else if (l < 6)  len = 5'($urandom_range(8, 1));
      else             len = 5'($urandom_range(24, 9));
      send_cmd(CMD_WRITE, sym, bits, len);
    end else if (r < 86) begin
      send_cmd(CMD_ENCODE, sym, bits, len);
    end else if (r < 96) begin
      send_cmd(CMD_FLUSH, sym, bits, len);
    end else begin
      send_cmd(CMD_UNKNOWN, sym, bits, len);
    end
  endtask

  task automatic test_random_stream(input int idle_pct, input int stall_pct, input int n);
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    for (int i = 0; i < n / 2; i++) send_random_cmd();
    wait_until_drained();
    for (int i = n / 2; i < n; i++) send_random_cmd();
  endtask

  initial begin
    int guard;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_WRITE;
    in_ch.symbol    = '0;
    in_ch.code_bits = '0;
    in_ch.code_len  = '0;
    in_idle_pct     = 0;
    out_stall_pct   = 0;
    mismatches      = 0;
    bytes_checked   = 0;
    n_write = 0; n_encode = 0; n_flush = 0; n_unknown = 0;
    pend_bits = '0;
    pend_cnt  = 0;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      code_value[i]  = '0;
      code_length[i] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_directed_codes();
    test_random_stream(0, 0, 71);
    test_random_stream(70, 0, 71);
    test_random_stream(0, 70, 71);
    test_random_stream(12, 12, 71);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    guard = 0;
    while (expected_bytes.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);

    $display("sent %0d commands: %0d writes, %0d encodes, %0d flushes, %0d unknown",
             n_write + n_encode + n_flush + n_unknown, n_write, n_encode, n_flush, n_unknown);
    $display("checked %0d packed bytes over four idle/stall mixes, %0d mismatches",
             bytes_checked, mismatches);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("huffman_code_bit_packer regression: pass");
    end else begin
      if (expected_bytes.size() != 0)
        $display("%0d expected bytes never arrived", expected_bytes.size());
      $display("huffman_code_bit_packer regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/hcbp_pkg.sv
src/hcbp_if.sv
src/hcbp_front.sv
src/hcbp_fifo.sv
src/hcbp_back.sv
src/huffman_code_bit_packer.sv
src/hcbp_chk.sv
test/testbench.sv
